// File: design/clps_pkg.sv
// Shared types and constants for the character LCD parallel sequencer.
// Request codes, status codes, power-up command table and buffer sizing.
// No dependencies.
package clps_pkg;

    localparam int CLPS_BUFFER_DEPTH = 32;

    localparam logic [7:0] CLPS_FIRST_ROW_RST  = 8'd128;
    localparam logic [7:0] CLPS_SECOND_ROW_RST = 8'd192;
    localparam logic [7:0] CLPS_CLEAR_CMD      = 8'h01;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_DATA  = 3'd1,
        CMD_RAW   = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_MOVE  = 3'd4
    } t_cmd_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_ERROR = 2'd2
    } t_status_e;

    typedef enum logic [0:0] {
        CFG_FIRST_ROW  = 1'b0,
        CFG_SECOND_ROW = 1'b1
    } t_cfg_idx_e;

    // Power-up command bytes, one per step
    function automatic logic [7:0] powerup_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        case (step)
            3'd0:    cmd = 8'b0011_0000;
            3'd1:    cmd = 8'b0011_0000;
            3'd2:    cmd = 8'b0011_0000;
            3'd3:    cmd = 8'b0011_1000;
            3'd4:    cmd = 8'b0000_1000;
            3'd5:    cmd = 8'b0000_0001;
            3'd6:    cmd = 8'b0000_0110;
            3'd7:    cmd = 8'b0000_1100;
            default: cmd = 8'b0000_1100;
        endcase
        return cmd;
    endfunction

endpackage

// File: design/clps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the data word buffer. No dependencies.
module clps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/char_lcd_parallel_sequencer.sv
// Character LCD 8-bit parallel bus sequencer, top level; depends on clps_pkg and clps_ram.
// The result of an accepted input transaction is registered in the output register.
// Throughput: one item per cycle while the output side takes results.
// The word buffer RAM is read every cycle at the next read position, so a
// data strobe tick finds its byte ready without a stall.
// Reset (i_rst_n low, synchronous) clears control state; power-up takes 32 ticks.
module char_lcd_parallel_sequencer
    import clps_pkg::*;
#(
    parameter int BUFFER_DEPTH = CLPS_BUFFER_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // value[7:0], row_select[8], column[14:9], zero[15]
    input  logic [2:0]  s_axis_tuser,  // command[2:0]
    input  logic        s_axis_tlast,  // last_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // enable_pin[0], read_write_pin[1],
                                       // register_select_pin[2], data_bus[10:3],
                                       // ready_res[11], zero[15:12]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        REQ_IDLE,
        REQ_DATA,
        REQ_CMD,
        REQ_CLEAR,
        REQ_MOVE
    } t_req_e;

    // configuration
    logic [7:0]    r_first_row, r_second_row;

    // control state
    logic          r_pu_done,   n_pu_done;
    logic [2:0]    r_pu_step,   n_pu_step;
    logic [1:0]    r_pu_tick,   n_pu_tick;
    t_req_e        r_req,       n_req;
    logic          r_phase,     n_phase;
    logic [7:0]    r_pending,   n_pending;
    logic [CW-1:0] r_bytes_left, n_bytes_left;
    logic [CW-1:0] r_read_pos,  n_read_pos;
    logic [CW-1:0] r_fill,      n_fill;
    logic          r_pin_en,    n_pin_en;
    logic          r_pin_rs,    n_pin_rs;
    logic [7:0]    r_pin_data,  n_pin_data;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [15:0]   r_out_data;

    // buffer access
    logic          buf_we;
    logic [AW-1:0] buf_waddr, buf_raddr;
    logic [7:0]    buf_rdata, buf_byte;
    logic          r_fwd_hit;
    logic [7:0]    r_fwd_data;

    logic          in_acc;
    t_cmd_e        cmd;
    logic [7:0]    in_value;
    logic [7:0]    row_base;
    t_status_e     n_status;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmd           = t_cmd_e'(s_axis_tuser);
    assign in_value      = s_axis_tdata[7:0];
    assign row_base      = s_axis_tdata[8] ? r_second_row : r_first_row;

    assign buf_waddr = r_fill[AW-1:0];
    assign buf_raddr = n_read_pos[AW-1:0];
    // a write to the entry being read this cycle lands after the read: forward it
    assign buf_byte  = r_fwd_hit ? r_fwd_data : buf_rdata;

    clps_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (in_value),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    always_comb begin
        n_pu_done    = r_pu_done;
        n_pu_step    = r_pu_step;
        n_pu_tick    = r_pu_tick;
        n_req        = r_req;
        n_phase      = r_phase;
        n_pending    = r_pending;
        n_bytes_left = r_bytes_left;
        n_read_pos   = r_read_pos;
        n_fill       = r_fill;
        n_pin_en     = r_pin_en;
        n_pin_rs     = r_pin_rs;
        n_pin_data   = r_pin_data;
        n_status     = ST_OK;
        buf_we       = 1'b0;

        if (in_acc) begin
            case (cmd)
                CMD_TICK: begin
                    if (!r_pu_done) begin
                        if (r_pu_tick == 2'd0) begin
                            n_pending  = powerup_cmd(r_pu_step);
                            n_pin_en   = 1'b1;
                            n_pin_rs   = 1'b0;
                            n_pin_data = powerup_cmd(r_pu_step);
                        end else if (r_pu_tick == 2'd1) begin
                            n_pin_en = 1'b0;
                        end
                        n_pu_tick = r_pu_tick + 2'd1;
                        if (r_pu_tick == 2'd3) begin
                            n_pu_step = r_pu_step + 3'd1;
                            if (r_pu_step == 3'd7) begin
                                n_pu_done = 1'b1;
                            end
                        end
                    end else if (r_req == REQ_DATA) begin
                        if (r_bytes_left != '0) begin
                            if (!r_phase) begin
                                n_pin_en   = 1'b1;
                                n_pin_rs   = 1'b1;
                                n_pin_data = buf_byte;
                                n_read_pos = r_read_pos + 1'b1;
                                n_phase    = 1'b1;
                            end else begin
                                n_pin_en     = 1'b0;
                                n_phase      = 1'b0;
                                n_bytes_left = r_bytes_left - 1'b1;
                            end
                        end else begin
                            // word done: empty the buffer
                            n_phase    = 1'b0;
                            n_read_pos = '0;
                            n_fill     = '0;
                            n_req      = REQ_IDLE;
                        end
                    end else if (r_req != REQ_IDLE) begin
                        if (!r_phase) begin
                            n_pin_en   = 1'b1;
                            n_pin_rs   = 1'b0;
                            n_pin_data = r_pending;
                            n_phase    = 1'b1;
                        end else begin
                            n_pin_en = 1'b0;
                            n_phase  = 1'b0;
                            n_req    = REQ_IDLE;
                        end
                    end
                end
                CMD_DATA, CMD_RAW, CMD_CLEAR, CMD_MOVE: begin
                    if (!r_pu_done || r_req != REQ_IDLE) begin
                        n_status = ST_BUSY;
                    end else begin
                        case (cmd)
                            CMD_DATA: begin
                                if (r_fill < DEPTH_C) begin
                                    buf_we = 1'b1;
                                    n_fill = r_fill + 1'b1;
                                end else begin
                                    n_status = ST_ERROR;
                                end
                                if (s_axis_tlast) begin
                                    n_req        = REQ_DATA;
                                    n_bytes_left = n_fill;
                                    n_read_pos   = '0;
                                    n_phase      = 1'b0;
                                end
                            end
                            CMD_RAW: begin
                                n_pending = in_value;
                                n_req     = REQ_CMD;
                            end
                            CMD_CLEAR: begin
                                n_pending = CLPS_CLEAR_CMD;
                                n_req     = REQ_CLEAR;
                            end
                            default: begin
                                n_pending = row_base + {2'b00, s_axis_tdata[14:9]};
                                n_req     = REQ_MOVE;
                            end
                        endcase
                    end
                end
                default: begin
                    n_status = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_row  <= CLPS_FIRST_ROW_RST;
            r_second_row <= CLPS_SECOND_ROW_RST;
            r_pu_done    <= 1'b0;
            r_pu_step    <= '0;
            r_pu_tick    <= '0;
            r_req        <= REQ_IDLE;
            r_phase      <= 1'b0;
            r_pending    <= '0;
            r_bytes_left <= '0;
            r_read_pos   <= '0;
            r_fill       <= '0;
            r_pin_en     <= 1'b0;
            r_pin_rs     <= 1'b0;
            r_pin_data   <= '0;
            r_out_valid  <= 1'b0;
            r_fwd_hit    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx_e'(i_cfg_index))
                    CFG_FIRST_ROW:  r_first_row  <= i_cfg_wdata;
                    CFG_SECOND_ROW: r_second_row <= i_cfg_wdata;
                    default:        r_first_row  <= r_first_row;
                endcase
            end
            r_pu_done    <= n_pu_done;
            r_pu_step    <= n_pu_step;
            r_pu_tick    <= n_pu_tick;
            r_req        <= n_req;
            r_phase      <= n_phase;
            r_pending    <= n_pending;
            r_bytes_left <= n_bytes_left;
            r_read_pos   <= n_read_pos;
            r_fill       <= n_fill;
            r_pin_en     <= n_pin_en;
            r_pin_rs     <= n_pin_rs;
            r_pin_data   <= n_pin_data;
            r_fwd_hit    <= buf_we && (buf_waddr == buf_raddr);
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_fwd_data <= in_value;
        if (in_acc) begin
            r_out_status <= n_status;
            r_out_data   <= {4'b0000, (n_pu_done && n_req == REQ_IDLE),
                             n_pin_data, n_pin_rs, 1'b0, n_pin_en};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("buffer fill count beyond depth");

    a_no_req_in_powerup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pu_done |-> (r_req == REQ_IDLE))
        else $error("request active during power-up");

    // read position and bytes left move in step with the strobe phase
    a_word_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req == REQ_DATA) |->
            ({1'b0, r_read_pos} + {1'b0, r_bytes_left}
             == {1'b0, r_fill} + {{CW{1'b0}}, r_phase}))
        else $error("data word counters out of step");

    a_idle_read_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req == REQ_IDLE) |-> (r_read_pos == '0 && !r_phase))
        else $error("read position or strobe phase not home while idle");

    a_buffer_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_we |-> (r_pu_done && r_req == REQ_IDLE))
        else $error("buffer written while busy");
`endif

endmodule
